// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// concurrent check under async active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// concurrent check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/ymr_pkg.sv -----
// ----------------------------------------------------------------------------
// ymr_pkg
// types and constants shared by the ymodem receiver modules
// ----------------------------------------------------------------------------
`default_nettype none
package ymr_pkg;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_END    = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_NUMBER = 3'd3;
  localparam logic [2:0] ST_COMPL  = 3'd4;
  localparam logic [2:0] ST_LENGTH = 3'd5;
  localparam logic [2:0] ST_CRC    = 3'd6;
  localparam logic [2:0] ST_CANCEL = 3'd7;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_INFO = 2'd1;
  localparam logic [1:0] EV_DATA = 2'd2;
  localparam logic [1:0] EV_EXIT = 2'd3;

  // what the back end must emit for one accepted item
  typedef enum logic [3:0] {
    ACT_NONE,      // nothing
    ACT_PAYLOAD,   // one payload byte
    ACT_TO_HDR,    // timeout in header phase: verdict, C
    ACT_EXIT,      // verdict exit, ACK, CA, CA
    ACT_INFO,      // verdict info, ACK, C
    ACT_DATA,      // verdict data, ACK
    ACT_END_ONLY,  // verdict end mark
    ACT_END_NAK,   // verdict end mark, NAK
    ACT_END_ACK,   // verdict end mark, ACK
    ACT_END_ACKC,  // verdict end mark, ACK, C
    ACT_BAD,       // verdict status, NAK
    ACT_PAY_BAD    // payload byte, verdict status, NAK
  } action_e;

  typedef struct packed {
    action_e     act;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [10:0] len;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ymodem_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// ymodem_receiver_unit
// ymodem receive side with crc-16 frame checks and reply generation
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  input    | in_valid_i/in_stall_o, mode, byte, end    | in
//  result   | out_valid_o/out_stall_i, kind..last       | out
//  config   | cfg_we_i, cfg_wdata_i (timeout_ticks)     | in
//
//  the parser takes one item per cycle while the queue has room
//  each item yields zero to four result items, one per cycle at the output while it is not stalled
//  a payload byte gives at most one result item; a frame end gives one to four result items
//  stall on the output holds the emitter; two queued commands absorb it
//  reset is asynchronous; timeout_ticks returns to 1000
// ----------------------------------------------------------------------------
`default_nettype none
module ymodem_receiver_unit import ymr_pkg::*; #(
  parameter int unsigned LONG_BLOCK  = 1024,
  parameter int unsigned SHORT_BLOCK = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       byte_value_o,
  output logic [2:0]       frame_status_o,
  output logic [1:0]       event_res_o,
  output logic [10:0]      payload_len_o,
  output logic             last_o
);

  logic [15:0] timeout_q;
  logic        take, full, empty, pop, push;
  cmd_t        cmd, head;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= 16'd1000;
    else if (cfg_we_i) timeout_q <= cfg_wdata_i;
  end

  // the queue is checked before the pop so the stall does not depend on out_stall_i
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;
  // items with no results leave nothing in the queue
  assign push       = take && (cmd.act != ACT_NONE);

  ymr_front #(.LONG_BLOCK(LONG_BLOCK), .SHORT_BLOCK(SHORT_BLOCK)) u_front (
    .clk_i, .rst_ni, .timeout_ticks_i(timeout_q), .take_i(take),
    .mode_i, .frame_byte_i, .frame_end_i, .cmd_o(cmd)
  );

  ymr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_cmd_i(cmd), .full_o(full),
    .empty_o(empty), .pop_i(pop), .head_o(head)
  );

  ymr_back u_back (
    .clk_i, .rst_ni, .have_i(!empty), .cmd_i(head), .pop_o(pop),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .result_kind_o, .byte_value_o,
    .frame_status_o, .event_res_o, .payload_len_o, .last_o
  );

endmodule
`default_nettype wire

// ----- hdl/ymr_front.sv -----
// ----------------------------------------------------------------------------
// ymr_front
// frame parser and session state, one command per accepted item
// ----------------------------------------------------------------------------
`default_nettype none
module ymr_front import ymr_pkg::*; #(
  parameter int unsigned LONG_BLOCK  = 1024,
  parameter int unsigned SHORT_BLOCK = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] timeout_ticks_i,
  input  wire logic        take_i,
  input  wire logic        mode_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output cmd_t             cmd_o
);

  localparam logic [1:0] TY_SHORT  = 2'd0;
  localparam logic [1:0] TY_LONG   = 2'd1;
  localparam logic [1:0] TY_END    = 2'd2;
  localparam logic [1:0] TY_CANCEL = 2'd3;
  localparam logic [10:0] LEN_L = 11'(LONG_BLOCK);
  localparam logic [10:0] LEN_S = 11'(SHORT_BLOCK);

  logic        phase_q, phase_d;
  logic [7:0]  pnum_q, pnum_d;
  logic        endm_q, endm_d;
  logic [15:0] tick_q, tick_d;
  logic [10:0] pos_q, pos_d;
  logic [1:0]  ftype_q, ftype_d;
  logic [15:0] crc_q, crc_d, rcrc_q, rcrc_d;
  logic [2:0]  pend_q, pend_d;
  logic        empty_q, empty_d;

  logic [10:0] len;
  logic [2:0]  st;
  logic [15:0] tick_inc;

  always_comb begin
    phase_d = phase_q; pnum_d = pnum_q; endm_d = endm_q; tick_d = tick_q;
    pos_d = pos_q; ftype_d = ftype_q; crc_d = crc_q; rcrc_d = rcrc_q;
    pend_d = pend_q; empty_d = empty_q;
    cmd_o = '{act: ACT_NONE, data: frame_byte_i, status: ST_OK, len: 11'd0};
    st = ST_OK;
    len = (ftype_q == TY_LONG) ? LEN_L : LEN_S;
    tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
    if (take_i) begin
      if (mode_i) begin
        tick_d = tick_inc;
        if (tick_inc >= timeout_ticks_i) begin
          pos_d = '0; ftype_d = '0; crc_d = '0; rcrc_d = '0; pend_d = '0; empty_d = 1'b0;
          cmd_o.act = phase_q ? ACT_EXIT : ACT_TO_HDR;
          phase_d = 1'b0; pnum_d = '0; endm_d = 1'b0; tick_d = '0;
        end
      end else begin
        if (pos_q == '0) begin
          priority if (frame_byte_i == CH_SOH) ftype_d = TY_SHORT;
          else if (frame_byte_i == CH_STX) ftype_d = TY_LONG;
          else if (frame_byte_i == CH_EOT || frame_byte_i == CH_ETX) ftype_d = TY_END;
          else if (frame_byte_i == CH_CAN) ftype_d = TY_CANCEL;
          else begin
            ftype_d = TY_END; pend_d = ST_HEADER;
          end
          len = (ftype_d == TY_LONG) ? LEN_L : LEN_S;
        end else if (ftype_q == TY_CANCEL) begin
          if (pos_q == 11'd1 && frame_byte_i != CH_CAN && pend_q == ST_OK) pend_d = ST_CANCEL;
        end else if (ftype_q == TY_SHORT || ftype_q == TY_LONG) begin
          if (pos_q == 11'd1) begin
            if (frame_byte_i != pnum_q && pend_q == ST_OK) pend_d = ST_NUMBER;
          end else if (pos_q == 11'd2) begin
            if (frame_byte_i != ~pnum_q && pend_q == ST_OK) pend_d = ST_COMPL;
          end else if ({1'b0, pos_q} < {1'b0, len} + 12'd3) begin
            crc_d = crc_byte(crc_q, frame_byte_i);
            if (pos_q == 11'd3) empty_d = (frame_byte_i == 8'h00);
            if (pend_q == ST_OK) cmd_o.act = ACT_PAYLOAD;
          end else begin
            rcrc_d = {rcrc_q[7:0], frame_byte_i};
          end
        end
        if (pos_q != 11'h7FF) pos_d = pos_q + 11'd1;
        if (frame_end_i) begin
          // first error wins, then type, then length, then crc
          priority if (pend_d != ST_OK) st = pend_d;
          else if (ftype_d == TY_CANCEL && pos_q == '0) st = ST_CANCEL;
          else if (ftype_d == TY_END || ftype_d == TY_CANCEL) st = ST_END;
          else if ({1'b0, pos_q} != {1'b0, len} + 12'd4) st = ST_LENGTH;
          else if (crc_d != rcrc_d) st = ST_CRC;
          else st = ST_OK;
          cmd_o.status = st;
          if (st == ST_OK) begin
            cmd_o.len = len;
            if (!phase_q) begin
              if (empty_d) begin
                cmd_o.act = ACT_EXIT;
                phase_d = 1'b0; pnum_d = '0; endm_d = 1'b0;
              end else begin
                cmd_o.act = ACT_INFO;
                pnum_d = pnum_q + 8'd1; endm_d = 1'b0; phase_d = 1'b1;
              end
            end else begin
              cmd_o.act = ACT_DATA;
              pnum_d = pnum_q + 8'd1; endm_d = 1'b0;
            end
          end else if (st == ST_END) begin
            if (endm_q) begin
              pnum_d = '0;
              cmd_o.act = phase_q ? ACT_END_ACKC : ACT_END_ACK;
              phase_d = 1'b0;
            end else begin
              cmd_o.act = phase_q ? ACT_END_NAK : ACT_END_ONLY;
            end
            endm_d = 1'b1;
          end else begin
            // a payload byte that ends a short frame still goes out ahead of the verdict
            cmd_o.act = (cmd_o.act == ACT_PAYLOAD) ? ACT_PAY_BAD : ACT_BAD;
            endm_d = 1'b0;
          end
          pos_d = '0; ftype_d = '0; crc_d = '0; rcrc_d = '0; pend_d = '0; empty_d = 1'b0;
          tick_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0; pnum_q <= '0; endm_q <= 1'b0; tick_q <= '0;
      pos_q <= '0; ftype_q <= '0; crc_q <= '0; rcrc_q <= '0; pend_q <= '0;
      empty_q <= 1'b0;
    end else begin
      phase_q <= phase_d; pnum_q <= pnum_d; endm_q <= endm_d; tick_q <= tick_d;
      pos_q <= pos_d; ftype_q <= ftype_d; crc_q <= crc_d; rcrc_q <= rcrc_d;
      pend_q <= pend_d; empty_q <= empty_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ymr_queue.sv -----
// ----------------------------------------------------------------------------
// ymr_queue
// two-entry command queue between parser and emitter
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ymr_queue import ymr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output cmd_t      head_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `ASSERT_CLK(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "queue overflow")
  `ASSERT_CLK(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "queue underflow")
  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")

endmodule
`default_nettype wire

// ----- hdl/ymr_back.sv -----
// ----------------------------------------------------------------------------
// ymr_back
// expands a command into its result items, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ymr_back import ymr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        have_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       byte_value_o,
  output logic [2:0]       frame_status_o,
  output logic [1:0]       event_res_o,
  output logic [10:0]      payload_len_o,
  output logic             last_o
);

  logic [1:0] idx_q;
  logic [1:0] n;
  logic [1:0] kind;
  logic [7:0] val;
  logic [2:0] st;
  logic [1:0] ev;
  logic [10:0] ln;
  logic       lst, go;
  logic       pay, vrd;

  // item count minus one and item content for step idx_q
  always_comb begin
    n = 2'd0; kind = KIND_REPLY; val = 8'h00; st = ST_OK; ev = EV_NONE; ln = '0;
    // a payload-led command shifts its verdict to the second step
    pay = (cmd_i.act == ACT_PAYLOAD) || (cmd_i.act == ACT_PAY_BAD && idx_q == 2'd0);
    vrd = (cmd_i.act == ACT_PAY_BAD) ? (idx_q == 2'd1) : (idx_q == 2'd0);
    unique case (cmd_i.act)
      ACT_PAYLOAD:  n = 2'd0;
      ACT_TO_HDR:   n = 2'd1;
      ACT_EXIT:     n = 2'd3;
      ACT_INFO:     n = 2'd2;
      ACT_DATA:     n = 2'd1;
      ACT_END_ONLY: n = 2'd0;
      ACT_END_NAK:  n = 2'd1;
      ACT_END_ACK:  n = 2'd1;
      ACT_END_ACKC: n = 2'd2;
      ACT_BAD:      n = 2'd1;
      ACT_PAY_BAD:  n = 2'd2;
      default:      n = 2'd0;
    endcase
    if (pay) begin
      kind = KIND_PAYLOAD; val = cmd_i.data;
    end else if (vrd) begin
      kind = KIND_VERDICT;
      unique case (cmd_i.act)
        ACT_EXIT: ev = EV_EXIT;
        ACT_INFO: begin ev = EV_INFO; ln = cmd_i.len; end
        ACT_DATA: begin ev = EV_DATA; ln = cmd_i.len; end
        ACT_END_ONLY, ACT_END_NAK, ACT_END_ACK, ACT_END_ACKC: st = ST_END;
        ACT_BAD, ACT_PAY_BAD: st = cmd_i.status;
        default: ev = EV_NONE;
      endcase
    end else begin
      unique case (cmd_i.act)
        ACT_TO_HDR: val = CH_C;
        ACT_EXIT:   val = (idx_q == 2'd1) ? CH_ACK : CH_CAN;
        ACT_INFO, ACT_END_ACKC: val = (idx_q == 2'd1) ? CH_ACK : CH_C;
        ACT_DATA, ACT_END_ACK: val = CH_ACK;
        default: val = CH_NAK;
      endcase
    end
    lst = (idx_q == n);
  end

  assign valid_o        = have_i;
  assign go             = have_i && !stall_i;
  assign pop_o          = go && lst;
  assign result_kind_o  = kind;
  assign byte_value_o   = val;
  assign frame_status_o = st;
  assign event_res_o    = ev;
  assign payload_len_o  = ln;
  assign last_o         = lst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (go) idx_q <= lst ? 2'd0 : idx_q + 2'd1;
  end

  `ASSERT_CLK(a_idx_bound, clk_i, rst_ni, !have_i || idx_q <= n, "step past command end")
  `ASSERT_CLK(a_idx_idle, clk_i, rst_ni, have_i || idx_q == 2'd0, "step set with no command")
  `ASSERT_CLK(a_hold, clk_i, rst_ni, (have_i && stall_i) |=> $stable(idx_q), "step moved under stall")

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ymodem receiver: frames and ticks go in, every
// payload byte, verdict and reply character coming out is compared with a
// cycle-free software image of the receiver kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import ymr_pkg::*;

  // result item as seen on the output channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  val;
    logic [2:0]  st;
    logic [1:0]  ev;
    logic [10:0] len;
    logic        last;
  } ymr_result_t;

  typedef enum logic [1:0] {FT_SHORT, FT_LONG, FT_END, FT_CANCEL} frame_kind_e;

  localparam int unsigned SHORT_LEN = 128;
  localparam int unsigned LONG_LEN  = 1024;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [7:0]  frame_byte_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  byte_value_o;
  logic [2:0]  frame_status_o;
  logic [1:0]  event_res_o;
  logic [10:0] payload_len_o;
  logic        last_o;

  ymodem_receiver_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .frame_byte_i   (frame_byte_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .byte_value_o   (byte_value_o),
    .frame_status_o (frame_status_o),
    .event_res_o    (event_res_o),
    .payload_len_o  (payload_len_o),
    .last_o         (last_o)
  );

  // results still owed by the block, oldest first
  ymr_result_t due_results[$];
  int          mismatch_count;

  // receiver image state
  logic        rx_phase;
  logic [7:0]  rx_pkt;
  logic        rx_end_seen;
  logic [15:0] rx_ticks;
  logic [10:0] rx_pos;
  frame_kind_e rx_kind;
  logic [15:0] rx_crc_run;
  logic [15:0] rx_crc_got;
  logic [2:0]  rx_pend;
  logic        rx_name_empty;
  logic [15:0] rx_timeout;
  int          rx_nres;

  // bench controls
  logic [7:0]  frame_q[$];
  bit          quiet;        // no gaps on either side
  int          hold_req;     // long output hold request, in cycles
  int          stall_left;

  // clock and watchdog
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver image
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) r = {r[14:0], 1'b0} ^ 16'h1021;
      else r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void owe(input logic [1:0] k, input logic [7:0] v,
                              input logic [2:0] s, input logic [1:0] e,
                              input logic [10:0] l);
    ymr_result_t r;
    r = '{kind: k, val: v, st: s, ev: e, len: l, last: 1'b0};
    due_results.push_back(r);
    rx_nres++;
  endfunction

  function automatic void frame_clear();
    rx_pos = '0;
    rx_kind = FT_SHORT;
    rx_crc_run = '0;
    rx_crc_got = '0;
    rx_pend = ST_OK;
    rx_name_empty = 1'b0;
  endfunction

  function automatic void session_restart();
    rx_phase = 1'b0;
    rx_pkt = '0;
    rx_end_seen = 1'b0;
    rx_ticks = '0;
  endfunction

  // verdict exit, then ack and the cancel pair
  function automatic void session_exit();
    owe(KIND_VERDICT, 8'h00, ST_OK, EV_EXIT, 11'd0);
    owe(KIND_REPLY, CH_ACK, ST_OK, EV_NONE, 11'd0);
    owe(KIND_REPLY, CH_CAN, ST_OK, EV_NONE, 11'd0);
    owe(KIND_REPLY, CH_CAN, ST_OK, EV_NONE, 11'd0);
    session_restart();
  endfunction

  function automatic void ymodem_predict(input logic m, input logic [7:0] b, input logic fin);
    int unsigned pos;
    int unsigned blen;
    logic [2:0]  st;
    pos = rx_pos;
    blen = (rx_kind == FT_LONG) ? LONG_LEN : SHORT_LEN;
    rx_nres = 0;
    if (m) begin
      if (rx_ticks != 16'hFFFF) rx_ticks++;
      if (rx_ticks >= rx_timeout) begin
        frame_clear();
        if (!rx_phase) begin
          owe(KIND_VERDICT, 8'h00, ST_OK, EV_NONE, 11'd0);
          owe(KIND_REPLY, CH_C, ST_OK, EV_NONE, 11'd0);
          session_restart();
        end else begin
          session_exit();
        end
      end
    end else begin
      if (pos == 0) begin
        case (b)
          CH_SOH:         rx_kind = FT_SHORT;
          CH_STX:         rx_kind = FT_LONG;
          CH_EOT, CH_ETX: rx_kind = FT_END;
          CH_CAN:         rx_kind = FT_CANCEL;
          default: begin
            rx_kind = FT_END;
            rx_pend = ST_HEADER;
          end
        endcase
        blen = (rx_kind == FT_LONG) ? LONG_LEN : SHORT_LEN;
      end else if (rx_kind == FT_CANCEL) begin
        if (pos == 1 && b != CH_CAN && rx_pend == ST_OK) rx_pend = ST_CANCEL;
      end else if (rx_kind == FT_SHORT || rx_kind == FT_LONG) begin
        if (pos == 1) begin
          if (b != rx_pkt && rx_pend == ST_OK) rx_pend = ST_NUMBER;
        end else if (pos == 2) begin
          if (b != ~rx_pkt && rx_pend == ST_OK) rx_pend = ST_COMPL;
        end else if (pos < 3 + blen) begin
          rx_crc_run = crc16_step(rx_crc_run, b);
          if (pos == 3) rx_name_empty = (b == 8'h00);
          if (rx_pend == ST_OK) owe(KIND_PAYLOAD, b, ST_OK, EV_NONE, 11'd0);
        end else begin
          rx_crc_got = {rx_crc_got[7:0], b};
        end
      end
      if (rx_pos != 11'h7FF) rx_pos++;

      if (fin) begin
        // first error wins, then frame shape, then crc
        if (rx_pend != ST_OK) st = rx_pend;
        else if (rx_kind == FT_CANCEL && pos == 0) st = ST_CANCEL;
        else if (rx_kind == FT_END || rx_kind == FT_CANCEL) st = ST_END;
        else if (pos != blen + 4) st = ST_LENGTH;
        else if (rx_crc_run != rx_crc_got) st = ST_CRC;
        else st = ST_OK;

        if (st == ST_OK) begin
          if (!rx_phase) begin
            if (rx_name_empty) begin
              session_exit();
            end else begin
              owe(KIND_VERDICT, 8'h00, ST_OK, EV_INFO, 11'(blen));
              owe(KIND_REPLY, CH_ACK, ST_OK, EV_NONE, 11'd0);
              owe(KIND_REPLY, CH_C, ST_OK, EV_NONE, 11'd0);
              rx_pkt++;
              rx_end_seen = 1'b0;
              rx_phase = 1'b1;
            end
          end else begin
            owe(KIND_VERDICT, 8'h00, ST_OK, EV_DATA, 11'(blen));
            owe(KIND_REPLY, CH_ACK, ST_OK, EV_NONE, 11'd0);
            rx_pkt++;
            rx_end_seen = 1'b0;
          end
        end else if (st == ST_END) begin
          owe(KIND_VERDICT, 8'h00, ST_END, EV_NONE, 11'd0);
          if (rx_end_seen) begin
            // second end mark in a row closes the file
            rx_pkt = '0;
            owe(KIND_REPLY, CH_ACK, ST_OK, EV_NONE, 11'd0);
            if (rx_phase) begin
              owe(KIND_REPLY, CH_C, ST_OK, EV_NONE, 11'd0);
              rx_phase = 1'b0;
            end
          end else if (rx_phase) begin
            owe(KIND_REPLY, CH_NAK, ST_OK, EV_NONE, 11'd0);
          end
          rx_end_seen = 1'b1;
        end else begin
          owe(KIND_VERDICT, 8'h00, st, EV_NONE, 11'd0);
          owe(KIND_REPLY, CH_NAK, ST_OK, EV_NONE, 11'd0);
          rx_end_seen = 1'b0;
        end
        frame_clear();
        rx_ticks = '0;
      end
    end
    if (rx_nres > 0) due_results[due_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall driver and result checker
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
      else stall_left = $urandom_range(0, 2);
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    ymr_result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, kind", result_kind_o, -1);
      end else begin
        w = due_results.pop_front();
        if (result_kind_o !== w.kind) report_mismatch("kind", result_kind_o, w.kind);
        if (byte_value_o !== w.val) report_mismatch("byte", byte_value_o, w.val);
        if (frame_status_o !== w.st) report_mismatch("status", frame_status_o, w.st);
        if (event_res_o !== w.ev) report_mismatch("event", event_res_o, w.ev);
        if (payload_len_o !== w.len) report_mismatch("length", payload_len_o, w.len);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // one item: offered at the falling edge, held until taken, then an optional gap
  task automatic send_item(input logic m, input logic [7:0] b, input logic fin);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = m;
    frame_byte_i = b;
    frame_end_i = fin;
    do @(posedge clk_i); while (in_stall_o);
    ymodem_predict(m, b, fin);
    if (quiet) gap = 0;
    else if ($urandom_range(0, 31) == 0) gap = $urandom_range(10, 50);
    else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      mode_i = 1'($urandom_range(0, 1));
      frame_byte_i = 8'($urandom_range(0, 255));
      frame_end_i = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_item(1'b0, frame_q[i], i == frame_q.size() - 1);
  endtask

  // well-formed data frame for the current packet number
  task automatic build_data(input bit long_f, input bit empty_name);
    logic [15:0] c;
    logic [7:0]  b;
    int unsigned n;
    n = long_f ? LONG_LEN : SHORT_LEN;
    c = '0;
    frame_q.delete();
    frame_q.push_back(long_f ? CH_STX : CH_SOH);
    frame_q.push_back(rx_pkt);
    frame_q.push_back(~rx_pkt);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0) b = empty_name ? 8'h00 : 8'($urandom_range(1, 255));
      c = crc16_step(c, b);
      frame_q.push_back(b);
    end
    frame_q.push_back(c[15:8]);
    frame_q.push_back(c[7:0]);
  endtask

  task automatic send_short_frame(input logic [7:0] a, input logic [7:0] b, input int n);
    frame_q.delete();
    frame_q.push_back(a);
    if (n > 1) frame_q.push_back(b);
    send_frame();
  endtask

  // drop the input, wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = 16'($urandom_range(0, 65535));
    rx_timeout = v;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_header_timeout();
    // default of 1000 ticks: a few ticks do nothing
    repeat (3) send_tick();
    write_timeout(16'd1);
    send_tick();
    send_tick();
    write_timeout(16'd3);
    send_item(1'b0, CH_SOH, 1'b0);
    repeat (3) send_tick();     // partial frame discarded
  endtask

  task automatic test_bad_frames();
    write_timeout(16'hFFFF);
    send_short_frame(8'hFF, 8'h00, 1);     // unknown first byte
    send_short_frame(8'h00, 8'h00, 2);
    send_short_frame(CH_CAN, 8'h00, 1);    // lone cancel byte
    send_short_frame(CH_CAN, 8'h55, 2);    // broken cancel pair
    send_short_frame(CH_CAN, CH_CAN, 2);   // cancel pair
    frame_q = '{CH_CAN, CH_CAN, 8'hA5, 8'h5A};
    send_frame();                          // extra bytes ignored
    send_short_frame(CH_EOT, 8'h00, 1);    // header phase, follows an end mark: ack
    send_short_frame(CH_ETX, 8'hFF, 2);    // another end mark in a row, ack
    send_short_frame(CH_SOH, 8'h00, 1);    // short data frame
  endtask

  task automatic test_header_and_data();
    build_data(1'b0, 1'b0);
    send_frame();                          // file info
    // bad number, a later complement error does not win
    frame_q = '{CH_SOH, rx_pkt ^ 8'h01, ~rx_pkt ^ 8'h80, 8'h11};
    send_frame();
    // bad complement, payload held back
    frame_q = '{CH_SOH, rx_pkt, ~rx_pkt ^ 8'h80, 8'h22, 8'h33};
    send_frame();
    // long frame cut short on a payload byte
    frame_q = '{CH_STX, rx_pkt, ~rx_pkt, 8'h44, 8'h55, 8'h66};
    send_frame();
  endtask

  task automatic test_backpressure();
    write_timeout(16'hFFFF);
    wait_idle();
    hold_req = 400;
    @(negedge clk_i);
    build_data(1'b0, 1'b0);
    send_frame();                          // file data
    // sender pause until all results are back
    wait_idle();
  endtask

  task automatic test_end_mark_and_data_timeout();
    send_short_frame(CH_EOT, 8'h00, 1);    // data phase, nak
    write_timeout(16'd2);
    send_item(1'b0, CH_STX, 1'b0);
    send_tick();
    send_tick();                           // exit from data phase
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    frame_byte_i = '0;
    frame_end_i = 1'b0;
    out_stall_i = 1'b0;
    quiet = 1'b0;
    hold_req = 0;
    stall_left = 0;
    mismatch_count = 0;
    rx_timeout = 16'd1000;
    session_restart();
    frame_clear();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_timeout();
    test_bad_frames();
    test_header_and_data();
    test_backpressure();
    test_end_mark_and_data_timeout();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
